// ===== src/kcp_pkg.sv =====
// shared types, constants and helpers of the complex kronecker product block
`default_nettype none

package kcp_pkg;

   localparam int VAL_W      = 3;
   localparam int WIRE_W     = 2;
   localparam int IDX_W      = 6;
   localparam int DATA_W     = 16;
   localparam int POS_W      = 8;
   localparam int DIM_W      = 9;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int MUL_W      = 2 * DATA_W;
   localparam int SUM_W      = MUL_W + 1;
   localparam int FRAC_W     = DATA_W - 1;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int SETTLE_W   = 2;

   localparam int MAX_DIM           = 16;
   localparam int MAX_B_ENTRIES_DEF = 64;
   localparam int RESULT_LIMIT      = 64;

   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   localparam logic [VAL_W-1:0]  VALUEDNESS_RST = 3'd2;
   localparam logic [WIRE_W-1:0] WIRES_A_RST    = 2'd1;
   localparam logic [WIRE_W-1:0] WIRES_B_RST    = 2'd1;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_STREAM = 1'b1;

   typedef enum logic [1:0] {
      REG_VALUEDNESS = 2'd0,
      REG_WIRES_A    = 2'd1,
      REG_WIRES_B    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_BASE,
      ST_RUN,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic                     cmd;
      logic [IDX_W-1:0]         elem_index;
      logic signed [DATA_W-1:0] re_in;
      logic signed [DATA_W-1:0] im_in;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]         out_index;
      logic signed [DATA_W-1:0] re_out;
      logic signed [DATA_W-1:0] im_out;
      logic                     last;
      logic                     size_error;
   } rsp_type;

   // bookkeeping that travels with each product through the multiply pipeline
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic             last;
      logic             err;
   } tag_type;

   function automatic logic [DIM_W-1:0] pow_dim(input logic [VAL_W-1:0]  base,
                                                input logic [WIRE_W-1:0] ex);
      logic [DIM_W-1:0] b;
      logic [DIM_W-1:0] sq;
      logic [DIM_W-1:0] r;
      b  = DIM_W'(base);
      sq = DIM_W'(b * b);
      unique case (ex)
         2'd0:    r = DIM_W'(1);
         2'd1:    r = b;
         2'd2:    r = sq;
         default: r = DIM_W'(sq * b);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/kcp_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module kcp_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [kcp_pkg::IDX_W-1:0]   dividend,
   input  wire logic [kcp_pkg::DIM_W-1:0]   divisor,
   output logic                             done,
   output logic [kcp_pkg::IDX_W-1:0]        quotient,
   output logic [kcp_pkg::DIM_W-1:0]        remainder
);

   localparam int CNT_W = $clog2(kcp_pkg::IDX_W);

   logic                          busy_ff,  busy_in;
   logic                          done_ff,  done_in;
   logic [CNT_W-1:0]              cnt_ff,   cnt_in;
   logic [kcp_pkg::IDX_W-1:0]     quo_ff,   quo_in;
   logic [kcp_pkg::DIM_W-1:0]     rem_ff,   rem_in;
   logic [kcp_pkg::DIM_W:0]       rem_sh;
   logic [kcp_pkg::DIM_W:0]       rem_sub;
   logic                          q_bit;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[kcp_pkg::IDX_W-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      q_bit   = (rem_sh >= {1'b0, divisor});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(kcp_pkg::IDX_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[kcp_pkg::IDX_W-2:0], q_bit};
         rem_in = q_bit ? rem_sub[kcp_pkg::DIM_W-1:0] : rem_sh[kcp_pkg::DIM_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/kcp_cmul.sv =====
// pipelined complex multiply with round half up and saturation to q1.15
`default_nettype none

module kcp_cmul (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire kcp_pkg::tag_type                    in_tag,
   input  wire logic signed [kcp_pkg::DATA_W-1:0]   a_re,
   input  wire logic signed [kcp_pkg::DATA_W-1:0]   a_im,
   input  wire logic signed [kcp_pkg::DATA_W-1:0]   b_re,
   input  wire logic signed [kcp_pkg::DATA_W-1:0]   b_im,
   output kcp_pkg::tag_type                         out_tag,
   output logic signed [kcp_pkg::DATA_W-1:0]        out_re,
   output logic signed [kcp_pkg::DATA_W-1:0]        out_im
);

   localparam int Q_W = kcp_pkg::SUM_W - kcp_pkg::FRAC_W;

   localparam logic signed [kcp_pkg::SUM_W-1:0] ROUND_HALF =
      kcp_pkg::SUM_W'(1) <<< (kcp_pkg::FRAC_W - 1);
   localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << kcp_pkg::FRAC_W) - 1);
   localparam logic signed [Q_W-1:0] SAT_LO = -(Q_W'(1) <<< kcp_pkg::FRAC_W);

   kcp_pkg::tag_type                     tag_p_ff, tag_s_ff, tag_o_ff;
   logic signed [kcp_pkg::MUL_W-1:0]     p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [kcp_pkg::SUM_W-1:0]     t_re_ff, t_im_ff;
   logic signed [kcp_pkg::SUM_W-1:0]     t_re_in, t_im_in;
   logic signed [Q_W-1:0]                q_re, q_im;
   logic signed [kcp_pkg::DATA_W-1:0]    re_ff, im_ff, re_in, im_in;

   function automatic logic signed [kcp_pkg::DATA_W-1:0] sat16(input logic signed [Q_W-1:0] q);
      logic signed [kcp_pkg::DATA_W-1:0] r;
      if (q > SAT_HI) begin
         r = SAT_HI[kcp_pkg::DATA_W-1:0];
      end else if (q < SAT_LO) begin
         r = SAT_LO[kcp_pkg::DATA_W-1:0];
      end else begin
         r = q[kcp_pkg::DATA_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      t_re_in = $signed({p_rr_ff[kcp_pkg::MUL_W-1], p_rr_ff})
              - $signed({p_ii_ff[kcp_pkg::MUL_W-1], p_ii_ff}) + ROUND_HALF;
      t_im_in = $signed({p_ri_ff[kcp_pkg::MUL_W-1], p_ri_ff})
              + $signed({p_ir_ff[kcp_pkg::MUL_W-1], p_ir_ff}) + ROUND_HALF;
      q_re    = t_re_ff[kcp_pkg::SUM_W-1:kcp_pkg::FRAC_W];
      q_im    = t_im_ff[kcp_pkg::SUM_W-1:kcp_pkg::FRAC_W];
      re_in   = tag_s_ff.err ? '0 : sat16(q_re);
      im_in   = tag_s_ff.err ? '0 : sat16(q_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_p_ff <= '0;
         tag_s_ff <= '0;
         tag_o_ff <= '0;
      end else if (advance) begin
         tag_p_ff <= in_tag;
         tag_s_ff <= tag_p_ff;
         tag_o_ff <= tag_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_rr_ff <= a_re * b_re;
         p_ii_ff <= a_im * b_im;
         p_ri_ff <= a_re * b_im;
         p_ir_ff <= a_im * b_re;
         t_re_ff <= t_re_in;
         t_im_ff <= t_im_in;
         re_ff   <= re_in;
         im_ff   <= im_in;
      end
   end

   assign out_tag = tag_o_ff;
   assign out_re  = re_ff;
   assign out_im  = im_ff;

endmodule

`default_nettype wire

// ===== src/complex_kronecker_product.sv =====
// complex kronecker product engine: right matrix store, index sequencer, product pipeline
//
//   channel   direction   handshake                     content
//   req       in          req_valid / req_ready         req_data: cmd, elem_index, re_in, im_in
//   rsp       out         rsp_valid / rsp_ready         rsp_data: out_index, re/im, last, error
//   csr       in          psel/penable/pwrite, pready   valuedness, wires_a, wires_b
//
// a load request writes one word of the right matrix store.
// a left element request is set up by the index divide, then the base position steps,
// then issues dim_b*dim_b store reads, one per cycle unless rsp_ready stalls them.
// after reset and after each register write, requests wait until derived sizes settle.
// store contents are undefined after reset until loaded; no clearing pass.
// rsp_ready low freezes read/multiply while a result is held; loads are taken while idle.
`default_nettype none

module complex_kronecker_product #(
   parameter int MAX_B_ENTRIES = kcp_pkg::MAX_B_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire kcp_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output kcp_pkg::rsp_type                         rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [kcp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [kcp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [kcp_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   localparam int ADDR_W  = $clog2(MAX_B_ENTRIES);
   localparam int WORD_W  = 2 * kcp_pkg::DATA_W;
   localparam int WIDE_W  = kcp_pkg::DIM_W;
   localparam int M1_W    = kcp_pkg::IDX_W + kcp_pkg::DIM_W;

   // configuration registers and derived sizes
   logic [kcp_pkg::VAL_W-1:0]    valuedness_ff;
   logic [kcp_pkg::WIRE_W-1:0]   wires_a_ff, wires_b_ff;
   logic [kcp_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic [kcp_pkg::DIM_W-1:0]    da_ff, db_ff;
   logic [kcp_pkg::PROD_W-1:0]   n_ff, nb_ff, da2_ff;
   logic                         err_ff, none_ff;
   logic [kcp_pkg::POS_W-1:0]    n8_ff;
   logic [ADDR_W-1:0]            nb_m1_ff;
   logic                         csr_we;
   logic [1:0]                   csr_idx;

   // sequencer
   kcp_pkg::state_type           state_ff, state_in;
   logic                         accept, accept_stream, stream_runs;
   logic                         advance, issue, issue_err;
   logic                         div_start, div_done;
   logic [kcp_pkg::IDX_W-1:0]    ra;
   logic [kcp_pkg::DIM_W-1:0]    ca;
   logic signed [kcp_pkg::DATA_W-1:0] a_re_ff, a_im_ff;
   logic [kcp_pkg::POS_W-1:0]    m1_ff, m2_ff, base_ff, row_ff, row_in;
   logic [kcp_pkg::POS_W-1:0]    m1_in, m2_in, base_in;
   logic [M1_W-1:0]              m1_full;
   logic [kcp_pkg::PROD_W-1:0]   m2_full;
   logic [2*kcp_pkg::POS_W-1:0]  base_full;
   logic [ADDR_W-1:0]            k_ff, k_in;
   logic [kcp_pkg::DIM_W-1:0]    cb_ff, cb_in;
   logic                         k_last, cb_wrap;
   kcp_pkg::tag_type             issue_tag;

   // store and first pipeline stage
   logic [WORD_W-1:0]            store_mem [MAX_B_ENTRIES];
   logic [WORD_W-1:0]            rd_ff;
   logic                         load_we;
   logic [WIDE_W-1:0]            idx_wide;
   logic [ADDR_W-1:0]            load_addr;
   kcp_pkg::tag_type             tag1_ff;
   logic signed [kcp_pkg::DATA_W-1:0] a_re1_ff, a_im1_ff;
   kcp_pkg::tag_type             out_tag;
   logic signed [kcp_pkg::DATA_W-1:0] out_re, out_im;

   // ---------------- configuration port ----------------

   assign csr_we  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      unique case (csr_idx)
         kcp_pkg::REG_VALUEDNESS: prdata = kcp_pkg::CSR_DATA_W'(valuedness_ff);
         kcp_pkg::REG_WIRES_A:    prdata = kcp_pkg::CSR_DATA_W'(wires_a_ff);
         kcp_pkg::REG_WIRES_B:    prdata = kcp_pkg::CSR_DATA_W'(wires_b_ff);
         default:                 prdata = '0;
      endcase
   end

   always_comb begin
      if (csr_we) begin
         settle_in = kcp_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - kcp_pkg::SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valuedness_ff <= kcp_pkg::VALUEDNESS_RST;
         wires_a_ff    <= kcp_pkg::WIRES_A_RST;
         wires_b_ff    <= kcp_pkg::WIRES_B_RST;
         settle_ff     <= kcp_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
         if (csr_we) begin
            unique case (csr_idx)
               kcp_pkg::REG_VALUEDNESS: valuedness_ff <= pwdata[kcp_pkg::VAL_W-1:0];
               kcp_pkg::REG_WIRES_A:    wires_a_ff    <= pwdata[kcp_pkg::WIRE_W-1:0];
               kcp_pkg::REG_WIRES_B:    wires_b_ff    <= pwdata[kcp_pkg::WIRE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // derived sizes, recomputed continuously over three register stages
   always_ff @(posedge clock) begin
      da_ff    <= kcp_pkg::pow_dim(valuedness_ff, wires_a_ff);
      db_ff    <= kcp_pkg::pow_dim(valuedness_ff, wires_b_ff);
      n_ff     <= kcp_pkg::PROD_W'(da_ff) * kcp_pkg::PROD_W'(db_ff);
      nb_ff    <= kcp_pkg::PROD_W'(db_ff) * kcp_pkg::PROD_W'(db_ff);
      da2_ff   <= kcp_pkg::PROD_W'(da_ff) * kcp_pkg::PROD_W'(da_ff);
      err_ff   <= (n_ff > kcp_pkg::PROD_W'(kcp_pkg::MAX_DIM))
               || (nb_ff > kcp_pkg::PROD_W'(MAX_B_ENTRIES))
               || (nb_ff > kcp_pkg::PROD_W'(kcp_pkg::RESULT_LIMIT));
      none_ff  <= (nb_ff == '0);
      n8_ff    <= n_ff[kcp_pkg::POS_W-1:0];
      nb_m1_ff <= ADDR_W'(nb_ff - kcp_pkg::PROD_W'(1));
   end

   // ---------------- sequencer ----------------

   assign advance       = !out_tag.valid || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign accept_stream = accept && (req_data.cmd == kcp_pkg::CMD_STREAM);
   assign stream_runs   = !none_ff
                       && (kcp_pkg::PROD_W'(req_data.elem_index) < da2_ff);
   assign k_last        = (k_ff == nb_m1_ff);
   assign cb_wrap       = ((cb_ff + kcp_pkg::DIM_W'(1)) == db_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kcp_pkg::ST_IDLE: begin
            if (accept_stream) begin
               if (err_ff) begin
                  state_in = kcp_pkg::ST_ERR;
               end else if (stream_runs) begin
                  state_in = kcp_pkg::ST_DIV;
               end
            end
         end
         kcp_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = kcp_pkg::ST_MUL;
            end
         end
         kcp_pkg::ST_MUL:  state_in = kcp_pkg::ST_BASE;
         kcp_pkg::ST_BASE: state_in = kcp_pkg::ST_RUN;
         kcp_pkg::ST_RUN: begin
            if (advance && k_last) begin
               state_in = kcp_pkg::ST_IDLE;
            end
         end
         kcp_pkg::ST_ERR: begin
            if (advance) begin
               state_in = kcp_pkg::ST_IDLE;
            end
         end
         default: state_in = kcp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      issue     = 1'b0;
      issue_err = 1'b0;
      unique case (state_ff)
         kcp_pkg::ST_IDLE: begin
            req_ready = (settle_ff == '0);
            div_start = req_valid && (settle_ff == '0)
                     && (req_data.cmd == kcp_pkg::CMD_STREAM) && !err_ff && stream_runs;
         end
         kcp_pkg::ST_RUN: issue = advance;
         kcp_pkg::ST_ERR: begin
            issue     = advance;
            issue_err = advance;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // the divider latches the index at the accepting edge
   kcp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.elem_index),
      .divisor   (da_ff),
      .done      (div_done),
      .quotient  (ra),
      .remainder (ca)
   );

   // position of the first product: ra*db*n + ca*db, all modulo 2**POS_W
   always_comb begin
      m1_full   = M1_W'(ra) * M1_W'(db_ff);
      m2_full   = kcp_pkg::PROD_W'(ca) * kcp_pkg::PROD_W'(db_ff);
      m1_in     = m1_full[kcp_pkg::POS_W-1:0];
      m2_in     = m2_full[kcp_pkg::POS_W-1:0];
      base_full = (2*kcp_pkg::POS_W)'(m1_ff) * (2*kcp_pkg::POS_W)'(n8_ff);
      base_in   = base_full[kcp_pkg::POS_W-1:0] + m2_ff;
   end

   always_comb begin
      k_in   = k_ff;
      cb_in  = cb_ff;
      row_in = row_ff;
      if (state_ff == kcp_pkg::ST_BASE) begin
         k_in   = '0;
         cb_in  = '0;
         row_in = '0;
      end else if (state_ff == kcp_pkg::ST_RUN && advance) begin
         k_in = k_ff + ADDR_W'(1);
         if (cb_wrap) begin
            cb_in  = '0;
            row_in = row_ff + n8_ff;
         end else begin
            cb_in = cb_ff + kcp_pkg::DIM_W'(1);
         end
      end
   end

   always_comb begin
      issue_tag.valid = issue;
      issue_tag.err   = issue_err;
      issue_tag.last  = issue_err || k_last;
      issue_tag.pos   = issue_err ? '0 : base_ff + row_ff + cb_ff[kcp_pkg::POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept_stream) begin
         a_re_ff <= req_data.re_in;
         a_im_ff <= req_data.im_in;
      end
      if (state_ff == kcp_pkg::ST_MUL) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
      if (state_ff == kcp_pkg::ST_BASE) begin
         base_ff <= base_in;
      end
      k_ff   <= k_in;
      cb_ff  <= cb_in;
      row_ff <= row_in;
   end

   // ---------------- right matrix store ----------------

   assign idx_wide  = WIDE_W'(req_data.elem_index);
   assign load_addr = idx_wide[ADDR_W-1:0];
   assign load_we   = accept && (req_data.cmd == kcp_pkg::CMD_LOAD)
                   && (idx_wide < WIDE_W'(MAX_B_ENTRIES));

   always_ff @(posedge clock) begin
      if (load_we) begin
         store_mem[load_addr] <= {req_data.im_in, req_data.re_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance && issue) begin
         rd_ff <= store_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_re1_ff <= a_re_ff;
         a_im1_ff <= a_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (advance) begin
         tag1_ff <= issue_tag;
      end
   end

   kcp_cmul u_cmul (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_tag  (tag1_ff),
      .a_re    (a_re1_ff),
      .a_im    (a_im1_ff),
      .b_re    (rd_ff[kcp_pkg::DATA_W-1:0]),
      .b_im    (rd_ff[WORD_W-1:kcp_pkg::DATA_W]),
      .out_tag (out_tag),
      .out_re  (out_re),
      .out_im  (out_im)
   );

   assign rsp_valid           = out_tag.valid;
   assign rsp_data.out_index  = out_tag.pos;
   assign rsp_data.re_out     = out_re;
   assign rsp_data.im_out     = out_im;
   assign rsp_data.last       = out_tag.last;
   assign rsp_data.size_error = out_tag.err;

endmodule

`default_nettype wire

// ===== verif/complex_kronecker_product_test.sv =====
// self-checking testbench for the complex kronecker product engine
module complex_kronecker_product_test;
   import kcp_pkg::*;

   localparam int NUM_FIXED = 15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr  = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic              pready;

   // configuration as the block holds it
   logic [VAL_W-1:0]  cfg_val = VALUEDNESS_RST;
   logic [WIRE_W-1:0] cfg_wa  = WIRES_A_RST;
   logic [WIRE_W-1:0] cfg_wb  = WIRES_B_RST;

   // right matrix as the block stores it
   logic signed [DATA_W-1:0] right_re [MAX_B_ENTRIES_DEF];
   logic signed [DATA_W-1:0] right_im [MAX_B_ENTRIES_DEF];
   bit                       loaded   [MAX_B_ENTRIES_DEF];

   req_type request_q [$];
   rsp_type product_q [$];
   rsp_type want;
   int      queued_n    = 0;
   int      accepted_n  = 0;
   int      error_count = 0;
   int      req_gap     = 0;
   int      rsp_stall   = 0;
   int      stall_draw;
   bit      steady      = 1'b0;

   int fixed_v  [NUM_FIXED] = '{2, 4, 2, 2, 3, 2, 4, 2, 7, 0, 0, 1, 3, 4, 3};
   int fixed_wa [NUM_FIXED] = '{2, 1, 3, 1, 1, 0, 0, 2, 3, 0, 1, 3, 2, 2, 0};
   int fixed_wb [NUM_FIXED] = '{2, 1, 1, 3, 1, 3, 2, 3, 3, 0, 1, 3, 0, 0, 2};

   complex_kronecker_product u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int dim_pow(input int base, input int ex);
      int r;
      r = 1;
      for (int i = 0; i < ex; i++) r = r * base;
      return r;
   endfunction

   // round half up from Q2.30 to Q1.15, then saturate
   function automatic logic signed [DATA_W-1:0] round_q15(input longint x);
      longint q;
      q = (x + 16384) >>> FRAC_W;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[DATA_W-1:0];
   endfunction

   function automatic bit size_fault(input int da, input int db);
      return (da * db > MAX_DIM) || (db * db > MAX_B_ENTRIES_DEF) || (db * db > RESULT_LIMIT);
   endfunction

   function automatic void predict_products(input req_type r);
      int     da, db, n, nb, ra, ca, rb, cb, pos, k;
      longint ar, ai, br, bi;
      rsp_type p;
      if (r.cmd == CMD_LOAD) begin
         right_re[r.elem_index] = r.re_in;
         right_im[r.elem_index] = r.im_in;
         return;
      end
      da = dim_pow(cfg_val, cfg_wa);
      db = dim_pow(cfg_val, cfg_wb);
      n  = da * db;
      nb = db * db;
      if (size_fault(da, db)) begin
         p = '0;
         p.last = 1'b1;
         p.size_error = 1'b1;
         product_q.push_back(p);
         return;
      end
      if (int'(r.elem_index) >= da * da || nb == 0) return;
      ra = r.elem_index / da;
      ca = r.elem_index % da;
      ar = $signed(r.re_in);
      ai = $signed(r.im_in);
      for (k = 0; k < nb; k++) begin
         rb  = k / db;
         cb  = k % db;
         br  = $signed(right_re[k]);
         bi  = $signed(right_im[k]);
         pos = (ra * db + rb) * n + ca * db + cb;
         p.out_index  = POS_W'(pos);
         p.re_out     = round_q15(ar * br - ai * bi);
         p.im_out     = round_q15(ar * bi + ai * br);
         p.last       = (k + 1 == nb);
         p.size_error = 1'b0;
         product_q.push_back(p);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
   endtask

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   task automatic push_req(input logic cmd, input int idx,
                           input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
      req_type r;
      r.cmd        = cmd;
      r.elem_index = IDX_W'(idx);
      r.re_in      = re;
      r.im_in      = im;
      if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
      request_q.push_back(r);
      queued_n++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted_n != queued_n || product_q.size() != 0) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (request_q.size() != 0) begin
            req_data  <= request_q.pop_front();
            req_valid <= 1'b1;
            req_gap   <= steady ? 0 : $urandom_range(0, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor, request predictor and result stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (product_q.size() == 0) begin
               report_mismatch("result with nothing pending, out_index", rsp_data.out_index, -1);
            end else begin
               want = product_q.pop_front();
               if (rsp_data.out_index !== want.out_index)
                  report_mismatch("out_index", rsp_data.out_index, want.out_index);
               if (rsp_data.re_out !== want.re_out)
                  report_mismatch("re_out", rsp_data.re_out, want.re_out);
               if (rsp_data.im_out !== want.im_out)
                  report_mismatch("im_out", rsp_data.im_out, want.im_out);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", rsp_data.last, want.last);
               if (rsp_data.size_error !== want.size_error)
                  report_mismatch("size_error", rsp_data.size_error, want.size_error);
            end
         end
         // predictions are pushed before the count moves so the drain check never races
         if (req_valid && req_ready) begin
            predict_products(req_data);
            accepted_n++;
         end
         if (rsp_valid && rsp_ready) begin
            stall_draw = steady ? 0 : $urandom_range(0, 3);
            rsp_stall <= stall_draw;
            rsp_ready <= (stall_draw == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= (rsp_stall == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int phase, nv, nwa, nwb, da, db, nb, top, pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset setting: 2x2 by 2x2, extremes and rounding corners
      push_req(CMD_LOAD, 0, 16'h8000, 16'h8000);
      push_req(CMD_LOAD, 1, 16'h7fff, 16'h8000);
      push_req(CMD_LOAD, 2, 16'h4000, 16'h0000);
      push_req(CMD_LOAD, 3, 16'hbfff, 16'h0001);
      push_req(CMD_STREAM, 0, 16'h8000, 16'h8000);
      push_req(CMD_STREAM, 1, 16'h7fff, 16'h7fff);
      push_req(CMD_STREAM, 2, 16'h0001, 16'h0000);
      push_req(CMD_STREAM, 3, 16'hffff, 16'hffff);
      push_req(CMD_STREAM, 63, 16'h1234, 16'h5678);
      push_req(CMD_STREAM, 4, 16'h7fff, 16'h8000);
      push_req(CMD_LOAD, 63, 16'h7fff, 16'hffff);
      push_req(CMD_STREAM, 2, 16'h8000, 16'h7fff);
      push_req(CMD_STREAM, 3, 16'h0000, 16'h0000);

      for (phase = 1; phase <= NUM_FIXED || queued_n < 480; phase++) begin
         wait_drained();
         // a request with no result may still be in setup
         repeat (100) @(posedge clock);
         if (phase <= NUM_FIXED) begin
            nv  = fixed_v[phase-1];
            nwa = fixed_wa[phase-1];
            nwb = fixed_wb[phase-1];
         end else if ($urandom_range(0, 2) != 0) begin
            nv  = $urandom_range(2, 4);
            nwa = $urandom_range(1, 3);
            nwb = $urandom_range(1, 3);
         end else begin
            nv  = $urandom_range(0, 7);
            nwa = $urandom_range(0, 3);
            nwb = $urandom_range(0, 3);
         end
         csr_write(REG_VALUEDNESS, CSR_DATA_W'(nv));
         csr_write(REG_WIRES_A, CSR_DATA_W'(nwa));
         csr_write(REG_WIRES_B, CSR_DATA_W'(nwb));
         cfg_val = VAL_W'(nv);
         cfg_wa  = WIRE_W'(nwa);
         cfg_wb  = WIRE_W'(nwb);
         steady  = ($urandom_range(0, 3) == 0);

         da = dim_pow(nv, nwa);
         db = dim_pow(nv, nwb);
         nb = db * db;
         // every entry the products will read must hold data first
         if (!size_fault(da, db))
            for (int k = 0; k < nb; k++)
               if (!loaded[k] || $urandom_range(0, 7) == 0)
                  push_req(CMD_LOAD, k, pick_sample(), pick_sample());
         top = (da * da > 64) ? 63 : da * da - 1;
         for (int i = 0; i < 20; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
               push_req(CMD_LOAD, $urandom_range(0, 63), pick_sample(), pick_sample());
            else if (pick < 25 || top < 0)
               push_req(CMD_STREAM, $urandom_range(0, 63), pick_sample(), pick_sample());
            else
               push_req(CMD_STREAM, $urandom_range(0, top), pick_sample(), pick_sample());
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/kcp_pkg.sv
src/kcp_divider.sv
src/kcp_cmul.sv
src/complex_kronecker_product.sv
verif/complex_kronecker_product_test.sv
